### rtl/core/swbc_pkg.sv
package swbc_pkg;

    typedef struct packed {
        logic signed [15:0] a_left;
        logic signed [15:0] a_right;
        logic signed [15:0] a_top;
        logic signed [15:0] a_bottom;
        logic signed [15:0] a_speed_x;
        logic signed [15:0] a_speed_y;
        logic signed [15:0] b_left;
        logic signed [15:0] b_right;
        logic signed [15:0] b_top;
        logic signed [15:0] b_bottom;
        logic signed [15:0] b_speed_x;
        logic signed [15:0] b_speed_y;
    } req_t;

    typedef struct packed {
        logic               collided;
        logic [1:0]         face_a;
        logic [1:0]         face_b;
        logic signed [15:0] a_rewound_x;
        logic signed [15:0] a_rewound_y;
        logic signed [15:0] b_rewound_x;
        logic signed [15:0] b_rewound_y;
        logic signed [15:0] contact_angle;
    } rsp_t;

    // edge difference magnitude, speed magnitude, time fraction shift
    localparam int NUM_W      = 16;
    localparam int DEN_W      = 16;
    localparam int FRAC_SHIFT = 12;
    localparam int QUOT_W     = NUM_W + FRAC_SHIFT;
    localparam int TIME_W     = 32;
    localparam int LANES      = 2;
    localparam int CTR_W      = 17;
    localparam int SQ_W       = 33;

    localparam logic [TIME_W-1:0] T_NONE = 32'hFFFF_FFFF;

    localparam int ANGLE_W = 18;
    localparam logic signed [ANGLE_W-1:0] PI_Q13 = 18'sd25736;

    localparam logic [1:0] FACE_LEFT   = 2'd0;
    localparam logic [1:0] FACE_RIGHT  = 2'd1;
    localparam logic [1:0] FACE_TOP    = 2'd2;
    localparam logic [1:0] FACE_BOTTOM = 2'd3;

    localparam logic        REG_MIN_SPEED_SQ = 1'b0;
    localparam logic [31:0] MIN_SPEED_SQ_RST = 32'd655;

    // state carried alongside the divider
    typedef struct packed {
        logic [SQ_W-1:0]         sq_x;
        logic [SQ_W-1:0]         sq_y;
        logic                    overlap;
        logic                    zero_x;
        logic                    zero_y;
        logic                    pos_x;
        logic                    pos_y;
        logic signed [CTR_W-1:0] ctr_ax;
        logic signed [CTR_W-1:0] ctr_ay;
        logic signed [CTR_W-1:0] ctr_bx;
        logic signed [CTR_W-1:0] ctr_by;
        logic signed [15:0]      spd_ax;
        logic signed [15:0]      spd_ay;
        logic signed [15:0]      spd_bx;
        logic signed [15:0]      spd_by;
    } mid_t;

    typedef struct packed {
        logic       collided;
        logic [1:0] face_a;
        logic [1:0] face_b;
    } hit_t;

    function automatic logic signed [ANGLE_W-1:0] atan_q13(input int i);
        case (i)
            0:       return 18'sd6434;
            1:       return 18'sd3798;
            2:       return 18'sd2007;
            3:       return 18'sd1019;
            4:       return 18'sd511;
            5:       return 18'sd256;
            6:       return 18'sd128;
            7:       return 18'sd64;
            8:       return 18'sd32;
            9:       return 18'sd16;
            10:      return 18'sd8;
            11:      return 18'sd4;
            12:      return 18'sd2;
            13:      return 18'sd1;
            default: return 18'sd0;
        endcase
    endfunction

endpackage

### rtl/core/swbc_div.sv
// Restoring divider, one quotient bit per stage, two lanes.
module swbc_div
    import swbc_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num [LANES],
    input  logic [DEN_W-1:0]  in_den [LANES],
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUOT_W-1:0] out_quot [LANES],
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [QUOT_W];
    logic [SIDE_W-1:0] side_reg  [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        logic              v_in;
        logic [SIDE_W-1:0] side_in;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                side_reg[k] <= side_in;
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [DEN_W-1:0]  rem_reg  [QUOT_W];
        logic [QUOT_W-1:0] dvd_reg  [QUOT_W];
        logic [QUOT_W-1:0] quot_reg [QUOT_W];
        logic [DEN_W-1:0]  den_reg  [QUOT_W];

        for (genvar k = 0; k < QUOT_W; k++) begin : g_bit
            logic [DEN_W-1:0]  rem_in;
            logic [QUOT_W-1:0] dvd_in;
            logic [QUOT_W-1:0] quot_in;
            logic [DEN_W-1:0]  den_in;
            logic [DEN_W:0]    trial;
            logic [DEN_W+1:0]  diff;

            if (k == 0) begin : g_first
                assign rem_in  = '0;
                assign dvd_in  = {in_num[l], {FRAC_SHIFT{1'b0}}};
                assign quot_in = '0;
                assign den_in  = in_den[l];
            end else begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign dvd_in  = dvd_reg[k-1];
                assign quot_in = quot_reg[k-1];
                assign den_in  = den_reg[k-1];
            end

            assign trial = {rem_in, dvd_in[QUOT_W-1]};
            assign diff  = {1'b0, trial} - {2'b00, den_in};

            always_ff @(posedge clk) begin
                if (en) begin
                    rem_reg[k]  <= diff[DEN_W+1] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
                    dvd_reg[k]  <= dvd_in << 1;
                    quot_reg[k] <= {quot_in[QUOT_W-2:0], ~diff[DEN_W+1]};
                    den_reg[k]  <= den_in;
                end
            end
        end

        assign out_quot[l] = quot_reg[QUOT_W-1];
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign out_side  = side_reg[QUOT_W-1];

endmodule

### rtl/core/swbc_rewind.sv
// (left + right)*2048 - speed*t, floored to an integer and saturated; four lanes, two stages.
module swbc_rewind
    import swbc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int SIDE_W     = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [TIME_W-1:0]            in_time,
    input  logic signed [CTR_W-1:0]      in_ctr   [4],
    input  logic signed [15:0]           in_speed [4],
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic signed [COORD_BITS-1:0] out_pos  [4],
    output logic [SIDE_W-1:0]            out_side
);

    localparam int PROD_W = 16 + TIME_W + 1;
    localparam int V_W    = PROD_W + 1;
    localparam int SH_W   = V_W - FRAC_SHIFT;
    localparam logic signed [SH_W-1:0] SAT_HI = (SH_W'(1) <<< (COORD_BITS - 1)) - SH_W'(1);
    localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

    logic              v1_reg;
    logic              v2_reg;
    logic [SIDE_W-1:0] side1_reg;
    logic [SIDE_W-1:0] side2_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            side1_reg <= in_side;
            side2_reg <= side1_reg;
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic signed [PROD_W-1:0]     prod_reg;
        logic signed [CTR_W-1:0]      ctr_reg;
        logic signed [V_W-1:0]        v;
        logic signed [SH_W-1:0]       sh;
        logic signed [COORD_BITS-1:0] pos_next;
        logic signed [COORD_BITS-1:0] pos_reg;

        always_ff @(posedge clk) begin
            if (en) begin
                prod_reg <= PROD_W'(in_speed[l] * $signed({1'b0, in_time}));
                ctr_reg  <= in_ctr[l];
                pos_reg  <= pos_next;
            end
        end

        assign v  = (V_W'(ctr_reg) <<< 11) - V_W'(prod_reg);
        assign sh = SH_W'(v >>> FRAC_SHIFT);

        always_comb begin
            if (sh > SAT_HI) begin
                pos_next = SAT_HI[COORD_BITS-1:0];
            end else if (sh < SAT_LO) begin
                pos_next = SAT_LO[COORD_BITS-1:0];
            end else begin
                pos_next = sh[COORD_BITS-1:0];
            end
        end

        assign out_pos[l] = pos_reg;
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;

endmodule

### rtl/core/swbc_cordic.sv
// Vectoring CORDIC, one micro-rotation per stage.
module swbc_cordic
    import swbc_pkg::*;
#(
    parameter int COORD_BITS   = 16,
    parameter int CORDIC_STEPS = 14,
    parameter int SIDE_W       = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [COORD_BITS:0] in_dx,
    input  logic signed [COORD_BITS:0] in_dy,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic signed [15:0]        out_angle,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int W = COORD_BITS + 12;

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] x0_next;
    logic signed [W-1:0] y0_next;
    logic signed [ANGLE_W-1:0] z0_next;

    logic                      v_reg    [CORDIC_STEPS+1];
    logic [SIDE_W-1:0]         side_reg [CORDIC_STEPS+1];
    logic                      zero_reg [CORDIC_STEPS+1];
    logic signed [W-1:0]       x_reg    [CORDIC_STEPS+1];
    logic signed [W-1:0]       y_reg    [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0] z_reg    [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0] zf;

    assign xs = W'(in_dx) <<< 8;
    assign ys = W'(in_dy) <<< 8;

    // left half plane: fold over by pi first
    always_comb begin
        if (xs < 0) begin
            x0_next = -xs;
            y0_next = -ys;
            z0_next = (ys >= 0) ? PI_Q13 : -PI_Q13;
        end else begin
            x0_next = xs;
            y0_next = ys;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            side_reg[0] <= in_side;
            zero_reg[0] <= (in_dx == '0) && (in_dy == '0);
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [W-1:0] xsh;
        logic signed [W-1:0] ysh;

        assign xsh = x_reg[k] >>> k;
        assign ysh = y_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                side_reg[k+1] <= side_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                if (y_reg[k] > 0) begin
                    x_reg[k+1] <= x_reg[k] + ysh;
                    y_reg[k+1] <= y_reg[k] - xsh;
                    z_reg[k+1] <= z_reg[k] + atan_q13(k);
                end else begin
                    x_reg[k+1] <= x_reg[k] - ysh;
                    y_reg[k+1] <= y_reg[k] + xsh;
                    z_reg[k+1] <= z_reg[k] - atan_q13(k);
                end
            end
        end
    end

    always_comb begin
        zf = z_reg[CORDIC_STEPS];
        if (zero_reg[CORDIC_STEPS]) begin
            zf = '0;
        end else if (zf > PI_Q13) begin
            zf = PI_Q13;
        end else if (zf < -PI_Q13) begin
            zf = -PI_Q13;
        end
    end

    assign out_angle = zf[15:0];
    assign out_valid = v_reg[CORDIC_STEPS];
    assign out_side  = side_reg[CORDIC_STEPS];

endmodule

### rtl/core/swept_box_collision.sv
// channel  dir  handshake         word
// req      in   req_valid/ready   req_t: two boxes, edges and speeds
// rsp      out  rsp_valid/ready   rsp_t: hit flag, faces, rewound centers, angle
// cfg      in   APB write/read    min_speed_sq at byte address 0
//
// One pair enters per cycle while req_ready is high; the path from the req
// handshake to the earliest rsp handshake runs through the 28-stage restoring
// divider and the CORDIC chain.
// rst_n clears all valid bits and sets min_speed_sq to 655.
// The whole pipe holds while rsp is valid and not taken; req_ready drops then.
module swept_box_collision
    import swbc_pkg::*;
#(
    parameter int COORD_BITS   = 16,
    parameter int CORDIC_STEPS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MID_W = $bits(mid_t);
    localparam int HIT_W = $bits(hit_t);
    localparam int RSP_W = $bits(rsp_t);

    logic        en;
    logic [31:0] min_speed_sq_reg;

    // config
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_SPEED_SQ) ? min_speed_sq_reg : '0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_speed_sq_reg <= MIN_SPEED_SQ_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MIN_SPEED_SQ)) begin
            min_speed_sq_reg <= pwdata;
        end
    end

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    assign en        = !rsp_valid_reg || rsp_ready;
    assign req_ready = en;

    // stage 1: capture word, relative speed
    logic               s1_valid_reg;
    req_t               s1_req_reg;
    logic signed [16:0] rx_reg;
    logic signed [16:0] ry_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s1_req_reg <= req;
            rx_reg     <= 17'(req.b_speed_x) - 17'(req.a_speed_x);
            ry_reg     <= 17'(req.b_speed_y) - 17'(req.a_speed_y);
        end
    end

    // stage 2: squares, overlap, divider operands
    logic signed [16:0] xc;
    logic signed [16:0] yc;
    logic signed [16:0] num_x;
    logic signed [16:0] num_y;
    logic signed [16:0] ax_hi;
    logic signed [16:0] ax_lo;
    logic signed [16:0] ay_hi;
    logic signed [16:0] ay_lo;
    mid_t               mid_next;
    logic [NUM_W-1:0]   num_next [LANES];
    logic [DEN_W-1:0]   den_next [LANES];

    logic               s2_valid_reg;
    mid_t               mid_reg;
    logic [NUM_W-1:0]   num_reg [LANES];
    logic [DEN_W-1:0]   den_reg [LANES];

    always_comb begin
        ax_hi = 17'((s1_req_reg.a_right < s1_req_reg.b_right) ? s1_req_reg.a_right
                                                               : s1_req_reg.b_right);
        ax_lo = 17'((s1_req_reg.a_left > s1_req_reg.b_left) ? s1_req_reg.a_left
                                                             : s1_req_reg.b_left);
        ay_hi = 17'((s1_req_reg.a_bottom < s1_req_reg.b_bottom) ? s1_req_reg.a_bottom
                                                                 : s1_req_reg.b_bottom);
        ay_lo = 17'((s1_req_reg.a_top > s1_req_reg.b_top) ? s1_req_reg.a_top
                                                           : s1_req_reg.b_top);
        xc = ax_hi - ax_lo;
        yc = ay_hi - ay_lo;

        num_x = (rx_reg > 0) ? 17'(s1_req_reg.b_right) - 17'(s1_req_reg.a_left)
                             : 17'(s1_req_reg.b_left) - 17'(s1_req_reg.a_right);
        num_y = (ry_reg > 0) ? 17'(s1_req_reg.b_bottom) - 17'(s1_req_reg.a_top)
                             : 17'(s1_req_reg.b_top) - 17'(s1_req_reg.a_bottom);

        num_next[0] = num_x[16] ? NUM_W'(-num_x) : num_x[NUM_W-1:0];
        num_next[1] = num_y[16] ? NUM_W'(-num_y) : num_y[NUM_W-1:0];
        den_next[0] = rx_reg[16] ? DEN_W'(-rx_reg) : rx_reg[DEN_W-1:0];
        den_next[1] = ry_reg[16] ? DEN_W'(-ry_reg) : ry_reg[DEN_W-1:0];

        mid_next.sq_x    = SQ_W'(rx_reg * rx_reg);
        mid_next.sq_y    = SQ_W'(ry_reg * ry_reg);
        mid_next.overlap = (xc > 0) && (yc > 0);
        mid_next.zero_x  = (rx_reg == '0);
        mid_next.zero_y  = (ry_reg == '0);
        mid_next.pos_x   = (rx_reg > 0);
        mid_next.pos_y   = (ry_reg > 0);
        mid_next.ctr_ax  = 17'(s1_req_reg.a_left) + 17'(s1_req_reg.a_right);
        mid_next.ctr_ay  = 17'(s1_req_reg.a_top) + 17'(s1_req_reg.a_bottom);
        mid_next.ctr_bx  = 17'(s1_req_reg.b_left) + 17'(s1_req_reg.b_right);
        mid_next.ctr_by  = 17'(s1_req_reg.b_top) + 17'(s1_req_reg.b_bottom);
        mid_next.spd_ax  = s1_req_reg.a_speed_x;
        mid_next.spd_ay  = s1_req_reg.a_speed_y;
        mid_next.spd_bx  = s1_req_reg.b_speed_x;
        mid_next.spd_by  = s1_req_reg.b_speed_y;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            mid_reg <= mid_next;
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // axis times
    logic              div_valid;
    logic [QUOT_W-1:0] quot [LANES];
    logic [MID_W-1:0]  div_side;
    mid_t              mid_d;

    swbc_div #(
        .SIDE_W (MID_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_side   (mid_reg),
        .out_valid (div_valid),
        .out_quot  (quot),
        .out_side  (div_side)
    );

    assign mid_d = mid_t'(div_side);

    // pick the earlier axis; y wins a tie
    logic [TIME_W-1:0]       tx;
    logic [TIME_W-1:0]       ty;
    logic [TIME_W-1:0]       t_sel;
    logic [SQ_W:0]           sq;
    hit_t                    hit_next;
    logic signed [CTR_W-1:0] ctr  [4];
    logic signed [15:0]      spd  [4];

    always_comb begin
        tx = mid_d.zero_x ? T_NONE : TIME_W'(quot[0]);
        ty = mid_d.zero_y ? T_NONE : TIME_W'(quot[1]);
        sq = {1'b0, mid_d.sq_x} + {1'b0, mid_d.sq_y};
        hit_next.collided = (sq >= (SQ_W+1)'(min_speed_sq_reg)) && mid_d.overlap;
        if (tx < ty) begin
            t_sel = tx;
            hit_next.face_a = mid_d.pos_x ? FACE_LEFT : FACE_RIGHT;
            hit_next.face_b = mid_d.pos_x ? FACE_RIGHT : FACE_LEFT;
        end else begin
            t_sel = ty;
            hit_next.face_a = mid_d.pos_y ? FACE_TOP : FACE_BOTTOM;
            hit_next.face_b = mid_d.pos_y ? FACE_BOTTOM : FACE_TOP;
        end
        ctr[0] = mid_d.ctr_ax;
        ctr[1] = mid_d.ctr_ay;
        ctr[2] = mid_d.ctr_bx;
        ctr[3] = mid_d.ctr_by;
        spd[0] = mid_d.spd_ax;
        spd[1] = mid_d.spd_ay;
        spd[2] = mid_d.spd_bx;
        spd[3] = mid_d.spd_by;
    end

    logic                         rw_valid;
    logic signed [COORD_BITS-1:0] pos [4];
    logic [HIT_W-1:0]             rw_side;
    hit_t                         hit_r;

    swbc_rewind #(
        .COORD_BITS (COORD_BITS),
        .SIDE_W     (HIT_W)
    ) u_rewind (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_time   (t_sel),
        .in_ctr    (ctr),
        .in_speed  (spd),
        .in_side   (hit_next),
        .out_valid (rw_valid),
        .out_pos   (pos),
        .out_side  (rw_side)
    );

    assign hit_r = hit_t'(rw_side);

    rsp_t                       part;
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;

    always_comb begin
        part.collided      = hit_r.collided;
        part.face_a        = hit_r.face_a;
        part.face_b        = hit_r.face_b;
        part.a_rewound_x   = 16'(pos[0]);
        part.a_rewound_y   = 16'(pos[1]);
        part.b_rewound_x   = 16'(pos[2]);
        part.b_rewound_y   = 16'(pos[3]);
        part.contact_angle = '0;
        dx = (COORD_BITS+1)'(pos[2]) - (COORD_BITS+1)'(pos[0]);
        dy = (COORD_BITS+1)'(pos[3]) - (COORD_BITS+1)'(pos[1]);
    end

    logic               cd_valid;
    logic signed [15:0] angle;
    logic [RSP_W-1:0]   cd_side;
    rsp_t               rsp_next;

    swbc_cordic #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STEPS (CORDIC_STEPS),
        .SIDE_W       (RSP_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rw_valid),
        .in_dx     (dx),
        .in_dy     (dy),
        .in_side   (part),
        .out_valid (cd_valid),
        .out_angle (angle),
        .out_side  (cd_side)
    );

    always_comb begin
        rsp_next = rsp_t'(cd_side);
        rsp_next.contact_angle = angle;
        if (!rsp_next.collided) begin
            rsp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end else if (en) begin
            rsp_valid_reg <= cd_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.collided) |-> (rsp == '0))
        else $error("miss word with nonzero fields");

    a_face_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.collided) |-> (rsp.face_b == (rsp.face_a ^ 2'd1)))
        else $error("contact faces do not oppose");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.contact_angle <= 16'sd25736 && rsp.contact_angle >= -16'sd25736))
        else $error("contact angle out of range");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("input ready does not follow output stall");
`endif

endmodule

### test/tb_swept_box_collision.sv
`timescale 1ns / 100ps

module tb_swept_box_collision;
    import swbc_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE      = 70;
    localparam longint NO_TIME  = 64'h0000_0000_FFFF_FFFF;
    localparam longint PI_Q     = 25736;
    localparam int  TURNS       = 14;
    localparam logic [2:0] ADDR_MIN_SPEED = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;

    localparam longint ATAN_TAB [0:13] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                           32, 16, 8, 4, 2, 1};

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] speed_floor;
    rsp_t        contact_q[$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_on;

    typedef struct {
        req_t w;
        bit   typed;
        rsp_t e;
    } dir_row_t;

    dir_row_t    dir_tab[$];

    swept_box_collision dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint escape_time(longint num, longint den);
        longint n;
        longint d;
        longint t;
        if (den == 0)
            return NO_TIME;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        t = (n <<< 12) / d;
        return (t > NO_TIME) ? NO_TIME : t;
    endfunction

    function automatic longint rewind_center(longint lo, longint hi, longint spd, longint t);
        longint v;
        v = ((lo + hi) * 2048 - spd * t) >>> 12;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    function automatic longint heading(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q : -PI_Q;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < TURNS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_TAB[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_TAB[i];
            end
            x = nx;
        end
        if (z > PI_Q)
            z = PI_Q;
        if (z < -PI_Q)
            z = -PI_Q;
        return z;
    endfunction

    function automatic rsp_t predict_contact(req_t w);
        rsp_t   r;
        longint rx;
        longint ry;
        longint xc;
        longint yc;
        longint tx;
        longint ty;
        longint t;
        longint axr;
        longint ayr;
        longint bxr;
        longint byr;
        r  = '0;
        rx = longint'(w.b_speed_x) - longint'(w.a_speed_x);
        ry = longint'(w.b_speed_y) - longint'(w.a_speed_y);
        if (rx * rx + ry * ry < longint'({32'd0, speed_floor}))
            return r;
        xc = ((w.a_right < w.b_right) ? w.a_right : w.b_right)
           - ((w.a_left > w.b_left) ? w.a_left : w.b_left);
        yc = ((w.a_bottom < w.b_bottom) ? w.a_bottom : w.b_bottom)
           - ((w.a_top > w.b_top) ? w.a_top : w.b_top);
        if (xc <= 0 || yc <= 0)
            return r;
        tx = (rx > 0) ? escape_time(longint'(w.b_right) - w.a_left, rx)
           : (rx < 0) ? escape_time(longint'(w.b_left) - w.a_right, rx) : NO_TIME;
        ty = (ry > 0) ? escape_time(longint'(w.b_bottom) - w.a_top, ry)
           : (ry < 0) ? escape_time(longint'(w.b_top) - w.a_bottom, ry) : NO_TIME;
        if (tx < ty)
        begin
            t = tx;
            r.face_b = (rx > 0) ? FACE_RIGHT : FACE_LEFT;
            r.face_a = (rx > 0) ? FACE_LEFT : FACE_RIGHT;
        end
        else
        begin
            // y faces win a tie
            t = ty;
            r.face_b = (ry > 0) ? FACE_BOTTOM : FACE_TOP;
            r.face_a = (ry > 0) ? FACE_TOP : FACE_BOTTOM;
        end
        axr = rewind_center(w.a_left, w.a_right, w.a_speed_x, t);
        ayr = rewind_center(w.a_top, w.a_bottom, w.a_speed_y, t);
        bxr = rewind_center(w.b_left, w.b_right, w.b_speed_x, t);
        byr = rewind_center(w.b_top, w.b_bottom, w.b_speed_y, t);
        r.collided      = 1'b1;
        r.a_rewound_x   = axr[15:0];
        r.a_rewound_y   = ayr[15:0];
        r.b_rewound_x   = bxr[15:0];
        r.b_rewound_y   = byr[15:0];
        r.contact_angle = 16'(heading(bxr - axr, byr - ayr));
        return r;
    endfunction

    function automatic req_t boxes(int al, int ar, int at, int ab, int avx, int avy,
                                   int bl, int br, int bt, int bb, int bvx, int bvy);
        req_t w;
        w.a_left = 16'(al);    w.a_right = 16'(ar);   w.a_top = 16'(at);
        w.a_bottom = 16'(ab);
        w.a_speed_x = 16'(avx); w.a_speed_y = 16'(avy);
        w.b_left = 16'(bl);    w.b_right = 16'(br);   w.b_top = 16'(bt);
        w.b_bottom = 16'(bb);
        w.b_speed_x = 16'(bvx); w.b_speed_y = 16'(bvy);
        return w;
    endfunction

    function automatic req_t random_pair();
        req_t w;
        int   cx;
        int   cy;
        int   hx;
        int   hy;
        if ($urandom_range(99) < 15)
            return req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        cx = $urandom_range(0, 4000) - 2000;
        cy = $urandom_range(0, 4000) - 2000;
        hx = $urandom_range(1, 800);
        hy = $urandom_range(1, 800);
        w.a_left = 16'(cx - hx);  w.a_right = 16'(cx + hx);
        w.a_top = 16'(cy - hy);   w.a_bottom = 16'(cy + hy);
        cx += $urandom_range(0, 1600) - 800;
        cy += $urandom_range(0, 1600) - 800;
        hx = $urandom_range(1, 800);
        hy = $urandom_range(1, 800);
        w.b_left = 16'(cx - hx);  w.b_right = 16'(cx + hx);
        w.b_top = 16'(cy - hy);   w.b_bottom = 16'(cy + hy);
        if ($urandom_range(9) < 2)
        begin
            w.a_speed_x = 16'($urandom); w.a_speed_y = 16'($urandom);
            w.b_speed_x = 16'($urandom); w.b_speed_y = 16'($urandom);
        end
        else
        begin
            w.a_speed_x = 16'($urandom_range(0, 4000) - 2000);
            w.a_speed_y = ($urandom_range(9) == 0) ? 16'sd0
                                                   : 16'($urandom_range(0, 4000) - 2000);
            w.b_speed_x = ($urandom_range(9) == 0) ? w.a_speed_x
                                                   : 16'($urandom_range(0, 4000) - 2000);
            w.b_speed_y = 16'($urandom_range(0, 4000) - 2000);
        end
        return w;
    endfunction

    task automatic add_row(input req_t w, input bit typed, input rsp_t e);
        dir_row_t row;
        row.w     = w;
        row.typed = typed;
        row.e     = e;
        dir_tab.insert(dir_tab.size(), row);
    endtask

    task automatic push_pair(input req_t w, input bit typed, input rsp_t e);
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        contact_q.insert(contact_q.size(), typed ? e : predict_contact(w));
        while (idle_on && $urandom_range(99) < 18)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (contact_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MIN_SPEED)
            speed_floor = value;
        @(posedge clk);
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
        begin
            idle_on = !(i >= 100 && i < 300);
            push_pair(random_pair(), 1'b0, '0);
            if (i == count / 2)
                drain();
        end
        drain();
    endtask

    task automatic check_field(input string name, input longint e, input longint a);
        if (e != a)
        begin
            errors++;
            $display("%0t %s: expected %0d, got %0d", $time, name, e, a);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t e;
        rsp_ready <= !idle_on || ($urandom_range(99) >= 18);
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (contact_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected word: expected none, got %p", $time, rsp);
            end
            else
            begin
                e = contact_q.pop_front();
                check_field("collided", e.collided, rsp.collided);
                check_field("face_a", e.face_a, rsp.face_a);
                check_field("face_b", e.face_b, rsp.face_b);
                check_field("a_rewound_x", e.a_rewound_x, rsp.a_rewound_x);
                check_field("a_rewound_y", e.a_rewound_y, rsp.a_rewound_y);
                check_field("b_rewound_x", e.b_rewound_x, rsp.b_rewound_x);
                check_field("b_rewound_y", e.b_rewound_y, rsp.b_rewound_y);
                check_field("contact_angle", e.contact_angle, rsp.contact_angle);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        speed_floor = 32'd655;
        idle_on     = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // still boxes, degenerate extremes, apart, and too slow: all but the last row read as no hit
        add_row(boxes(0,0,0,0,0,0,0,0,0,0,0,0), 1'b1, '0);
        add_row(req_t'({12{16'sh7FFF}}), 1'b1, '0);
        add_row(req_t'({12{16'sh8000}}), 1'b1, '0);
        add_row(boxes(0,10,0,10,0,0,100,120,0,10,256,0), 1'b1, '0);
        add_row(boxes(0,100,0,100,0,0,50,150,50,150,25,0), 1'b1, '0);
        add_row(boxes(-32768,32767,-32768,32767,-32768,32767,
                      0,100,0,100,32767,-32768), 1'b0, '0);
        // each sweep direction, ties, one still axis, shared center
        add_row(boxes(0,100,0,100,0,0,50,150,40,60,512,0), 1'b0, '0);
        add_row(boxes(0,100,0,100,0,0,-50,50,40,60,-512,0), 1'b0, '0);
        add_row(boxes(0,100,0,100,0,0,40,60,50,150,0,512), 1'b0, '0);
        add_row(boxes(0,100,0,100,0,0,40,60,-50,50,0,-512), 1'b0, '0);
        add_row(boxes(0,100,0,100,0,0,50,150,50,150,256,256), 1'b0, '0);
        add_row(boxes(0,100,0,100,0,0,50,150,50,150,-256,-256), 1'b0, '0);
        add_row(boxes(0,100,0,100,300,-300,0,100,0,100,-300,300), 1'b0, '0);
        add_row(boxes(0,100,0,100,0,100,50,150,0,100,0,-100), 1'b0, '0);
        add_row(boxes(-30000,30000,-30000,30000,32767,-32768,
                      -29000,29000,-29000,29000,-32768,32767), 1'b0, '0);
        add_row(boxes(0,16,0,16,-1,0,1,17,1,17,1,0), 1'b0, '0);
        foreach (dir_tab[i])
            push_pair(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].e);
        drain();

        write_reg(ADDR_UNUSED, 32'h1234_5678);
        write_reg(ADDR_MIN_SPEED, 32'd0);
        // no relative motion at all: sentinel time on both axes; the last pair moves on x only
        push_pair(boxes(0,100,0,100,0,0,50,150,50,150,0,0), 1'b0, '0);
        push_pair(boxes(0,100,0,100,300,-200,50,150,50,150,300,-200), 1'b0, '0);
        push_pair(boxes(0,100,0,100,0,0,50,150,50,150,1,0), 1'b0, '0);
        drain();

        random_run(250);
        write_reg(ADDR_MIN_SPEED, 32'hFFFF_FFFF);
        random_run(50);
        write_reg(ADDR_MIN_SPEED, $urandom_range(0, 2000000));
        random_run(300);
        write_reg(ADDR_MIN_SPEED, 32'd655);
        random_run(550);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
